// ===== src/nsps_pkg.sv =====
package nsps_pkg;

  // Item modes
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 1'd1;

  localparam logic [14:0] TOLERANCE_RESET   = 15'd128;
  localparam logic [3:0]  ENABLE_MASK_RESET = 4'hF;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [1:0]         cand_type;
    logic [7:0]         cand_priority;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] snap_x;
    logic signed [15:0] snap_y;
    logic [1:0]         snap_type;
    logic [7:0]         snap_priority;
    logic [32:0]        distance_sq;
    logic [6:0]         entry_count;
    logic               overflow;
  } out_item_t;

  // One stored candidate, 42 bits
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         ctype;
    logic [7:0]         prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic pipe_empty;
  } status_t;

endpackage

// ===== src/nsps_in_if.sv =====
interface nsps_in_if;
  import nsps_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/nsps_out_if.sv =====
interface nsps_out_if;
  import nsps_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/nsps_ram.sv =====
module nsps_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/nsps_ctrl.sv =====
module nsps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nsps_pkg::status_t st,
  output nsps_pkg::cmd_t    cmd
);
  import nsps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept    = in_valid && in_ready;
    cmd.scan_step = (state == S_SCAN);
    cmd.load_out  = (state == S_RESULT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            in_ready <= 1'b0;
            state    <= st.start_scan ? S_SCAN : S_RESULT;
          end
        end
        S_SCAN: begin
          if (st.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (st.pipe_empty) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (cmd.load_out) begin
            in_ready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/nsps_dp.sv =====
module nsps_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  nsps_pkg::in_item_t            in_data,
  output nsps_pkg::out_item_t           out_data,
  input  nsps_pkg::cmd_t                cmd,
  output nsps_pkg::status_t             st
);
  import nsps_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Configuration
  logic [14:0] tolerance;
  logic [3:0]  enable_mask;
  logic [29:0] tol_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= TOLERANCE_RESET;
      enable_mask <= ENABLE_MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE:   tolerance   <= cfg_wdata[14:0];
        CFG_ENABLE_MASK: enable_mask <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tol_sq <= 30'(tolerance) * 30'(tolerance);
  end

  // Table bookkeeping
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               full;
  logic               ram_we;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic signed [15:0] qx;
  logic signed [15:0] qy;

  assign full   = (count == CW'(TABLE_DEPTH));
  assign ram_we = cmd.accept && (in_data.mode == MODE_ADD) && !full;

  always_comb begin
    wr_entry.x     = in_data.point_x;
    wr_entry.y     = in_data.point_y;
    wr_entry.ctype = in_data.cand_type;
    wr_entry.prio  = in_data.cand_priority;
  end

  nsps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (idx[AW-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      unique case (in_data.mode)
        MODE_ADD:   if (!full) count <= count + CW'(1);
        MODE_CLEAR: count <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qx  <= in_data.point_x;
      qy  <= in_data.point_y;
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + CW'(1);
    end
  end

  // Distance pipeline: difference, square, sum, select
  logic               v0, v1, v2, v3;
  logic signed [16:0] dx, dy;
  logic signed [16:0] dx1, dy1;
  logic signed [33:0] sqx, sqy;
  logic [31:0]        dx2, dy2;
  logic [32:0]        dist3;
  logic               en1, en2, en3;
  entry_t             e1, e2, e3;

  assign dx  = {rd_entry.x[15], rd_entry.x} - {qx[15], qx};
  assign dy  = {rd_entry.y[15], rd_entry.y} - {qy[15], qy};
  assign sqx = 34'(dx1) * 34'(dx1);
  assign sqy = 34'(dy1) * 34'(dy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= cmd.scan_step;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= dx;
    dy1   <= dy;
    en1   <= enable_mask[rd_entry.ctype];
    e1    <= rd_entry;
    dx2   <= sqx[31:0];
    dy2   <= sqy[31:0];
    en2   <= en1;
    e2    <= e1;
    dist3 <= {1'b0, dx2} + {1'b0, dy2};
    en3   <= en2;
    e3    <= e2;
  end

  // Best candidate so far
  logic        best_found;
  logic [32:0] best_dist;
  entry_t      best;
  logic        res_ovf;
  logic        take;

  assign take = v3 && en3 && (dist3 <= {3'd0, tol_sq}) &&
                (!best_found || (dist3 < best_dist) ||
                 ((dist3 == best_dist) && (e3.prio < best.prio)));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best_found <= 1'b0;
      best_dist  <= '0;
      best       <= '0;
      res_ovf    <= (in_data.mode == MODE_ADD) && full;
    end else if (take) begin
      best_found <= 1'b1;
      best_dist  <= dist3;
      best       <= e3;
    end
  end

  // Output register
  logic [CW+6:0] cnt_ext;
  out_item_t     res;

  assign cnt_ext = {7'd0, count};

  always_comb begin
    res.found         = best_found;
    res.snap_x        = best.x;
    res.snap_y        = best.y;
    res.snap_type     = best.ctype;
    res.snap_priority = best.prio;
    res.distance_sq   = best_dist;
    res.entry_count   = cnt_ext[6:0];
    res.overflow      = res_ovf;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  always_comb begin
    st.start_scan = (in_data.mode == MODE_QUERY) && (count != '0);
    st.scan_last  = (idx == count - CW'(1));
    st.pipe_empty = !(v0 || v1 || v2 || v3);
  end
endmodule

// ===== src/nearest_snap_point_search_top.sv =====
// Nearest snap point search.
// item_in carries one transaction per item: mode selects add candidate, clear
// table or query point. result_out returns exactly one transaction per item:
// for a query the nearest enabled candidate within the tolerance (lower
// priority value wins a tie, earliest kept otherwise), plus the entry count
// and, for an add into a full table, the overflow flag.
// Configuration: cfg_we/cfg_index/cfg_wdata write tolerance (index 0) and
// enable_mask (index 1); write them only while no item is in flight.
// Add, clear, ignored modes and queries on an empty table go from acceptance
// straight to the result state, which loads the output register once it is
// free; the next item can be accepted in the cycle after that load. A query
// reads one entry per cycle from the RAM's single read port, then drains a
// 4-stage difference, square, sum and select pipeline before the result loads,
// and the next item can follow in the cycle after that load.
// The output register lets the next item be accepted while a result waits;
// when result_out stalls, the following result is held internally and the
// block stops accepting until the output register frees up.
// Reset (rst, synchronous) empties the table, drops any pending result and
// restores tolerance 128 and enable_mask 4'hF. The RAM itself is not cleared.
module nearest_snap_point_search_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  nsps_in_if.sink                         item_in,
  nsps_out_if.source                      result_out
);
  import nsps_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer: handshakes and scan control
  nsps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table, distance pipeline, best tracking and output register
  nsps_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (item_in.data),
    .out_data  (result_out.data),
    .cmd       (cmd),
    .st        (st)
  );
endmodule
